### src/mpt_pkg.sv
// Shared types and constants for the marker presence tracker.
package mpt_pkg;

  localparam int MarkerSlots = 64;
  localparam int CoordBits   = 16;
  localparam int SlotIdxW    = $clog2(MarkerSlots);
  localparam int DivBits     = 8;
  localparam int EvBits      = 17;

  localparam logic [DivBits-1:0] DivisorReset = 8'd10;

  typedef logic [CoordBits-1:0]   coord_t;
  typedef logic [SlotIdxW-1:0]    slot_idx_t;
  typedef logic [MarkerSlots-1:0] slot_vec_t;
  typedef logic [DivBits-1:0]     divisor_t;

  typedef enum logic [1:0] {
    KIND_DETECTED = 2'd0,
    KIND_MOVED    = 2'd1,
    KIND_LOST     = 2'd2
  } event_kind_e;

  // position store access request
  typedef struct packed {
    logic      we;
    logic      re;
    slot_idx_t addr;
    coord_t    wx;
    coord_t    wy;
  } mem_req_t;

endpackage

### src/mpt_move_unit.sv
// Shared movement test: divisor * |now - stored| > stored.
module mpt_move_unit (
  input  mpt_pkg::divisor_t divisor_i,
  input  mpt_pkg::coord_t   stored_i,
  input  mpt_pkg::coord_t   now_i,
  output logic              moved_o
);

  localparam int ProdW = mpt_pkg::DivBits + mpt_pkg::CoordBits;

  mpt_pkg::coord_t  diff;
  logic [ProdW-1:0] prod;

  always_comb begin
    diff = (now_i >= stored_i) ? (now_i - stored_i) : (stored_i - now_i);
    prod = ProdW'(divisor_i) * ProdW'(diff);
    moved_o = prod > ProdW'(stored_i);
  end

endmodule

### src/mpt_pos_mem.sv
// Stored marker positions, one write port, one registered read port.
module mpt_pos_mem (
  input  logic              clk_i,
  input  mpt_pkg::mem_req_t req_i,
  output mpt_pkg::coord_t   rd_x_o,
  output mpt_pkg::coord_t   rd_y_o
);

  mpt_pkg::coord_t mem_x [mpt_pkg::MarkerSlots];
  mpt_pkg::coord_t mem_y [mpt_pkg::MarkerSlots];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_x[req_i.addr] <= req_i.wx;
      mem_y[req_i.addr] <= req_i.wy;
    end
    if (req_i.re) begin
      rd_x_o <= mem_x[req_i.addr];
      rd_y_o <= mem_y[req_i.addr];
    end
  end

endmodule

### src/marker_presence_tracker_unit.sv
// Marker presence tracker: sequencer, presence flags and output register.
// Unknown id goes to S_EMIT; known id goes through S_CMPX and S_CMPY, then to S_EMIT
// only when it moved. End of frame: S_SWEEP scans slots up to the last lost id.
// Every emit waits while the one-deep output register is still held.
// Reset clears presence and seen flags and sets move_divisor to 10; stored
// positions are undefined until written and need no clearing.
module marker_presence_tracker_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [mpt_pkg::DivBits-1:0]     move_divisor_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            op_i,
  input  logic [5:0]                      marker_id_i,
  input  logic [15:0]                     pos_x_i,
  input  logic [15:0]                     pos_y_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [1:0]                      event_kind_o,
  output logic [5:0]                      event_id_o,
  output logic signed [mpt_pkg::EvBits-1:0] event_x_o,
  output logic signed [mpt_pkg::EvBits-1:0] event_y_o,
  output logic                            last_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMPX,
    S_CMPY,
    S_EMIT,
    S_SWEEP
  } state_e;

  state_e                    state_q;
  mpt_pkg::divisor_t         div_q;
  mpt_pkg::slot_vec_t        present_q, seen_q, lost_q;
  mpt_pkg::slot_idx_t        id_q, scan_q;
  mpt_pkg::coord_t           x_q, y_q;
  mpt_pkg::event_kind_e      kind_q;
  logic                      move_x_q;

  logic                      out_valid_q, out_last_q;
  mpt_pkg::event_kind_e      out_kind_q;
  mpt_pkg::slot_idx_t        out_id_q;
  logic [mpt_pkg::EvBits-1:0] out_x_q, out_y_q;

  mpt_pkg::mem_req_t  mem_req;
  mpt_pkg::coord_t    rd_x, rd_y;
  mpt_pkg::coord_t    in_x, in_y, unit_stored, unit_now;
  mpt_pkg::slot_idx_t in_idx;
  mpt_pkg::slot_vec_t lost_rest;
  logic               in_acc, obs_acc, id_ok, unit_moved, moved_any, out_free;

  always_comb begin
    in_ready_o  = (state_q == S_IDLE);
    in_acc      = in_valid_i && in_ready_o;
    id_ok       = int'(marker_id_i) < mpt_pkg::MarkerSlots;
    in_idx      = mpt_pkg::SlotIdxW'(marker_id_i);
    in_x        = mpt_pkg::coord_t'(pos_x_i);
    in_y        = mpt_pkg::coord_t'(pos_y_i);
    obs_acc     = in_acc && !op_i && id_ok;
    unit_stored = (state_q == S_CMPX) ? rd_x : rd_y;
    unit_now    = (state_q == S_CMPX) ? x_q : y_q;
    moved_any   = move_x_q || unit_moved;
    out_free    = !out_valid_q || out_ready_i;
    lost_rest   = lost_q & ~(mpt_pkg::slot_vec_t'(1) << scan_q);

    mem_req.re   = obs_acc;
    mem_req.addr = (state_q == S_IDLE) ? in_idx : id_q;
    mem_req.wx   = (state_q == S_IDLE) ? in_x : x_q;
    mem_req.wy   = (state_q == S_IDLE) ? in_y : y_q;
    mem_req.we   = (obs_acc && !present_q[in_idx]) ||
                   ((state_q == S_CMPY) && moved_any);
  end

  mpt_move_unit u_move (
    .divisor_i (div_q),
    .stored_i  (unit_stored),
    .now_i     (unit_now),
    .moved_o   (unit_moved)
  );

  mpt_pos_mem u_mem (
    .clk_i  (clk_i),
    .req_i  (mem_req),
    .rd_x_o (rd_x),
    .rd_y_o (rd_y)
  );

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      div_q       <= mpt_pkg::DivisorReset;
      present_q   <= '0;
      seen_q      <= '0;
      lost_q      <= '0;
      scan_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        div_q <= move_divisor_i;
      end
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc && op_i) begin
            lost_q    <= present_q & ~seen_q;
            present_q <= present_q & seen_q;
            seen_q    <= '0;
            scan_q    <= '0;
            state_q   <= S_SWEEP;
          end else if (obs_acc) begin
            id_q           <= in_idx;
            x_q            <= in_x;
            y_q            <= in_y;
            seen_q[in_idx] <= 1'b1;
            if (!present_q[in_idx]) begin
              present_q[in_idx] <= 1'b1;
              kind_q            <= mpt_pkg::KIND_DETECTED;
              state_q           <= S_EMIT;
            end else begin
              state_q <= S_CMPX;
            end
          end
        end
        S_CMPX: begin
          move_x_q <= unit_moved;
          state_q  <= S_CMPY;
        end
        S_CMPY: begin
          if (moved_any) begin
            kind_q  <= mpt_pkg::KIND_MOVED;
            state_q <= S_EMIT;
          end else begin
            state_q <= S_IDLE;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_kind_q  <= kind_q;
            out_id_q    <= id_q;
            out_x_q     <= mpt_pkg::EvBits'(x_q);
            out_y_q     <= mpt_pkg::EvBits'(y_q);
            out_last_q  <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        S_SWEEP: begin
          if (lost_q == '0) begin
            state_q <= S_IDLE;
          end else if (!lost_q[scan_q]) begin
            scan_q <= scan_q + 1'b1;
          end else if (out_free) begin
            out_valid_q <= 1'b1;
            out_kind_q  <= mpt_pkg::KIND_LOST;
            out_id_q    <= scan_q;
            out_x_q     <= '1;
            out_y_q     <= '1;
            out_last_q  <= (lost_rest == '0);
            lost_q      <= lost_rest;
            scan_q      <= scan_q + 1'b1;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign event_kind_o = out_kind_q;
  assign event_id_o   = 6'(out_id_q);
  assign event_x_o    = out_x_q;
  assign event_y_o    = out_y_q;
  assign last_o       = out_last_q;

  a_lost_neg_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && event_kind_o == mpt_pkg::KIND_LOST) |->
      (event_x_o == -17'sd1 && event_y_o == -17'sd1))
    else $error("lost beat without -1 position");

  a_sweep_clears_seen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && op_i) |=> (seen_q == '0 && state_q == S_SWEEP))
    else $error("seen marks not cleared by sweep");

  a_lost_not_present: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lost_q & present_q) == '0)
    else $error("pending lost slot still present");

  a_emit_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && out_free) |=> (out_valid_o && last_o))
    else $error("observation beat not marked last");

endmodule
